@@ design/cssr_pkg.sv @@
// Package for the current soft-start ramp: widths, phase codes, register
// indexes and control state types. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cssr_pkg;

    // Field and register widths
    localparam int CURRENT_WIDTH = 16;
    localparam int TIME_WIDTH    = 24;
    localparam int STEP_WIDTH    = 16;
    localparam int THRESH_WIDTH  = 15;
    localparam int PHASE_WIDTH   = 2;

    // Derived widths
    localparam int PROD_WIDTH    = CURRENT_WIDTH + TIME_WIDTH;
    localparam int CNT_WIDTH     = $clog2(CURRENT_WIDTH);
    localparam int CMP_WIDTH     = (CURRENT_WIDTH > THRESH_WIDTH) ?
                                   CURRENT_WIDTH : THRESH_WIDTH;
    localparam int S_DATA_WIDTH  = ((CURRENT_WIDTH + STEP_WIDTH + 7) / 8) * 8;
    localparam int M_DATA_WIDTH  = ((CURRENT_WIDTH + PHASE_WIDTH + 7) / 8) * 8;

    // Configuration port
    localparam int CFG_ADDR_WIDTH = 2;
    localparam int CFG_DATA_WIDTH = TIME_WIDTH;
    localparam logic [CFG_ADDR_WIDTH-1:0] CFG_RAMP_DURATION   = 2'd0;
    localparam logic [CFG_ADDR_WIDTH-1:0] CFG_START_THRESHOLD = 2'd1;
    localparam logic [CFG_ADDR_WIDTH-1:0] CFG_STOP_THRESHOLD  = 2'd2;

    // Register reset values
    localparam logic [TIME_WIDTH-1:0]   RAMP_DURATION_RST   = TIME_WIDTH'(500000);
    localparam logic [THRESH_WIDTH-1:0] START_THRESHOLD_RST = THRESH_WIDTH'(100);
    localparam logic [THRESH_WIDTH-1:0] STOP_THRESHOLD_RST  = THRESH_WIDTH'(50);

    // Shaper phase codes
    typedef enum logic [PHASE_WIDTH-1:0] {
        PH_IDLE   = 2'd0,
        PH_RAMP   = 2'd1,
        PH_NORMAL = 2'd2
    } phase_t;

    // Source of the shaped current
    typedef enum logic [1:0] {
        OSEL_ZERO,
        OSEL_PASS,
        OSEL_RAMP
    } out_sel_t;

    // Sequencer states
    typedef enum logic [1:0] {
        CS_IDLE,
        CS_MUL,
        CS_DIV,
        CS_OUT
    } ctl_state_t;

    // Start/finish pair between the sequencer and a serial unit
    typedef struct packed {
        logic start;
    } unit_cmd_t;

    typedef struct packed {
        logic done;
    } unit_sts_t;

endpackage : cssr_pkg

`default_nettype wire

@@ design/cssr_mul.sv @@
// Serial shift-add multiplier: one multiplier bit per cycle.
// Depends on cssr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cssr_mul import cssr_pkg::*; (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire unit_cmd_t                cmd,
    input  wire logic [CURRENT_WIDTH-1:0] mag,
    input  wire logic [TIME_WIDTH-1:0]    mult,
    output      unit_sts_t                sts,
    output      logic [PROD_WIDTH-1:0]    product
);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_WIDTH-1:0]  cnt_reg, cnt_next;
    logic [PROD_WIDTH-1:0] prod_reg, prod_next;
    logic [TIME_WIDTH-1:0] mcand_reg, mcand_next;
    logic [TIME_WIDTH:0]   sum;

    // Add the multiplicand into the upper half when the low bit is set
    always_comb begin
        sum = {1'b0, prod_reg[PROD_WIDTH-1:CURRENT_WIDTH]}
            + (prod_reg[0] ? {1'b0, mcand_reg} : '0);
    end

    // Step control: load on start, shift right one bit per cycle
    always_comb begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        prod_next  = prod_reg;
        mcand_next = mcand_reg;
        if (cmd.start) begin
            busy_next  = 1'b1;
            cnt_next   = CNT_WIDTH'(CURRENT_WIDTH - 1);
            prod_next  = {{TIME_WIDTH{1'b0}}, mag};
            mcand_next = mult;
        end else if (busy_reg) begin
            prod_next = {sum, prod_reg[CURRENT_WIDTH-1:1]};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath needs no reset
    always_ff @(posedge aclk) begin
        prod_reg  <= prod_next;
        mcand_reg <= mcand_next;
    end

    assign sts.done = done_reg;
    assign product  = prod_reg;

endmodule : cssr_mul

`default_nettype wire

@@ design/cssr_div.sv @@
// Serial restoring divider: one quotient bit per cycle. The upper part of the
// dividend must be below the divisor. Depends on cssr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cssr_div import cssr_pkg::*; (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire unit_cmd_t                cmd,
    input  wire logic [PROD_WIDTH-1:0]    dividend,
    input  wire logic [TIME_WIDTH-1:0]    divisor,
    output      unit_sts_t                sts,
    output      logic [CURRENT_WIDTH-1:0] quotient
);

    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;
    logic [CNT_WIDTH-1:0]     cnt_reg, cnt_next;
    logic [TIME_WIDTH-1:0]    rem_reg, rem_next;
    logic [CURRENT_WIDTH-1:0] quo_reg, quo_next;
    logic [TIME_WIDTH-1:0]    dvs_reg, dvs_next;
    logic [TIME_WIDTH+1:0]    diff;
    logic                     borrow;

    // Trial subtract of the divisor from the shifted remainder
    always_comb begin
        diff   = {1'b0, rem_reg, quo_reg[CURRENT_WIDTH-1]} - {2'b00, dvs_reg};
        borrow = diff[TIME_WIDTH+1];
    end

    // Step control: load on start, one quotient bit per cycle
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (cmd.start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_WIDTH'(CURRENT_WIDTH - 1);
            rem_next  = dividend[PROD_WIDTH-1:CURRENT_WIDTH];
            quo_next  = dividend[CURRENT_WIDTH-1:0];
            dvs_next  = divisor;
        end else if (busy_reg) begin
            rem_next = borrow ? {rem_reg[TIME_WIDTH-2:0], quo_reg[CURRENT_WIDTH-1]}
                              : diff[TIME_WIDTH-1:0];
            quo_next = {quo_reg[CURRENT_WIDTH-2:0], ~borrow};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign sts.done = done_reg;
    assign quotient = quo_reg;

endmodule : cssr_div

`default_nettype wire

@@ design/current_soft_start_ramp_top.sv @@
// Soft-start shaper for a q-axis current target: phase sequencing, config
// registers and output register. Uses cssr_pkg, cssr_mul and cssr_div.
// An accepted beat moves to the output state, which loads the output register and raises
// m_tvalid; a ramp beat that scales runs the serial multiplier, then the divider, first.
// A new beat is taken only after the previous result is loaded into the output register;
// a result held by m_tready stalls that load. Reset (aresetn low, synchronous): phase
// idle, timer zero, registers to defaults.
`timescale 1ns / 1ps
`default_nettype none

module current_soft_start_ramp_top import cssr_pkg::*; (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    // Configuration write port
    input  wire logic                      cfg_we,
    input  wire logic [CFG_ADDR_WIDTH-1:0] cfg_addr,
    input  wire logic [CFG_DATA_WIDTH-1:0] cfg_wdata,
    // Input stream
    input  wire logic                      s_tvalid,
    output      logic                      s_tready,
    input  wire logic [S_DATA_WIDTH-1:0]   s_tdata,  // target_current, time_step
    // Result stream
    output      logic                      m_tvalid,
    input  wire logic                      m_tready,
    output      logic [M_DATA_WIDTH-1:0]   m_tdata   // shaped_current, phase, zero pad
);

    // Configuration registers
    logic [TIME_WIDTH-1:0]   dur_reg;
    logic [THRESH_WIDTH-1:0] start_thr_reg;
    logic [THRESH_WIDTH-1:0] stop_thr_reg;

    // Shaper state
    phase_t                   phase_reg, phase_next;
    logic [TIME_WIDTH-1:0]    elapsed_reg, elapsed_next;
    ctl_state_t               state_reg, state_next;
    out_sel_t                 sel_reg, sel_next;
    logic [CURRENT_WIDTH-1:0] tgt_reg, tgt_next;
    logic                     neg_reg, neg_next;

    // Output register
    logic                     m_valid_reg, m_valid_next;
    logic [CURRENT_WIDTH-1:0] m_shaped_reg, m_shaped_next;
    logic [PHASE_WIDTH-1:0]   m_phase_reg, m_phase_next;

    // Beat decode
    logic [CURRENT_WIDTH-1:0] in_tgt;
    logic [STEP_WIDTH-1:0]    in_dt;
    logic                     in_neg;
    logic [CURRENT_WIDTH-1:0] in_mag;
    logic [TIME_WIDTH:0]      t_sum;
    logic                     t_reached;
    logic                     above_start;
    logic                     below_stop;
    logic                     s_accept;
    logic                     out_free;

    // Serial unit links
    unit_cmd_t                mul_cmd, div_cmd;
    unit_sts_t                mul_sts, div_sts;
    logic [PROD_WIDTH-1:0]    product;
    logic [CURRENT_WIDTH-1:0] quotient;
    logic [CURRENT_WIDTH-1:0] shaped;

    // Write configuration registers, masked to their widths
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dur_reg       <= RAMP_DURATION_RST;
            start_thr_reg <= START_THRESHOLD_RST;
            stop_thr_reg  <= STOP_THRESHOLD_RST;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_RAMP_DURATION:   dur_reg       <= cfg_wdata[TIME_WIDTH-1:0];
                CFG_START_THRESHOLD: start_thr_reg <= cfg_wdata[THRESH_WIDTH-1:0];
                CFG_STOP_THRESHOLD:  stop_thr_reg  <= cfg_wdata[THRESH_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // Decode the incoming beat: magnitude, advanced timer, threshold tests
    always_comb begin
        in_tgt      = s_tdata[CURRENT_WIDTH-1:0];
        in_dt       = s_tdata[CURRENT_WIDTH+STEP_WIDTH-1:CURRENT_WIDTH];
        in_neg      = in_tgt[CURRENT_WIDTH-1];
        in_mag      = in_neg ? (~in_tgt + 1'b1) : in_tgt;
        t_sum       = (TIME_WIDTH+1)'(elapsed_reg) + (TIME_WIDTH+1)'(in_dt);
        t_reached   = t_sum >= {1'b0, dur_reg};
        above_start = CMP_WIDTH'(in_mag) > CMP_WIDTH'(start_thr_reg);
        below_stop  = CMP_WIDTH'(in_mag) < CMP_WIDTH'(stop_thr_reg);
    end

    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    // Signed ramp value from the unsigned quotient
    assign shaped = neg_reg ? (~quotient + 1'b1) : quotient;

    // Sequencer register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= CS_IDLE;
            phase_reg   <= PH_IDLE;
            elapsed_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            elapsed_reg <= elapsed_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Hold the beat payload and the result fields
    always_ff @(posedge aclk) begin
        sel_reg      <= sel_next;
        tgt_reg      <= tgt_next;
        neg_reg      <= neg_next;
        m_shaped_reg <= m_shaped_next;
        m_phase_reg  <= m_phase_next;
    end

    // Next state: update the phase on accept, run the units for a ramp beat, then deliver
    always_comb begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        elapsed_next  = elapsed_reg;
        sel_next      = sel_reg;
        tgt_next      = tgt_reg;
        neg_next      = neg_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_shaped_next = m_shaped_reg;
        m_phase_next  = m_phase_reg;
        mul_cmd.start = 1'b0;
        div_cmd.start = 1'b0;
        s_tready      = 1'b0;

        unique case (state_reg)
            CS_IDLE: begin
                s_tready = 1'b1;
                if (s_accept) begin
                    tgt_next   = in_tgt;
                    neg_next   = in_neg;
                    state_next = CS_OUT;
                    unique case (phase_reg)
                        PH_IDLE: begin
                            sel_next = OSEL_ZERO;
                            if (above_start) begin
                                phase_next   = PH_RAMP;
                                elapsed_next = '0;
                            end
                        end
                        PH_RAMP: begin
                            if (t_reached) begin
                                phase_next   = PH_NORMAL;
                                elapsed_next = dur_reg;
                                sel_next     = OSEL_PASS;
                            end else begin
                                elapsed_next  = t_sum[TIME_WIDTH-1:0];
                                sel_next      = OSEL_RAMP;
                                mul_cmd.start = 1'b1;
                                state_next    = CS_MUL;
                            end
                        end
                        PH_NORMAL: begin
                            sel_next = OSEL_PASS;
                            if (below_stop) begin
                                phase_next   = PH_IDLE;
                                elapsed_next = '0;
                            end
                        end
                        default: begin
                            phase_next = PH_IDLE;
                            sel_next   = OSEL_ZERO;
                        end
                    endcase
                end
            end
            CS_MUL: begin
                if (mul_sts.done) begin
                    div_cmd.start = 1'b1;
                    state_next    = CS_DIV;
                end
            end
            CS_DIV: begin
                if (div_sts.done) begin
                    state_next = CS_OUT;
                end
            end
            CS_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_phase_next = phase_reg;
                    case (sel_reg)
                        OSEL_PASS: m_shaped_next = tgt_reg;
                        OSEL_RAMP: m_shaped_next = shaped;
                        default:   m_shaped_next = '0;
                    endcase
                    state_next = CS_IDLE;
                end
            end
            default: state_next = CS_IDLE;
        endcase
    end

    // Serial multiplier: magnitude times advanced timer
    cssr_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (mul_cmd),
        .mag     (in_mag),
        .mult    (t_sum[TIME_WIDTH-1:0]),
        .sts     (mul_sts),
        .product (product)
    );

    // Serial divider: product over ramp duration
    cssr_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (div_cmd),
        .dividend (product),
        .divisor  (dur_reg),
        .sts      (div_sts),
        .quotient (quotient)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_DATA_WIDTH - CURRENT_WIDTH - PHASE_WIDTH){1'b0}},
                       m_phase_reg, m_shaped_reg};

    // Multiplier finishes only while the sequencer waits for it
    assert property (@(posedge aclk) disable iff (!aresetn)
        mul_sts.done |-> state_reg == CS_MUL)
        else $error("multiplier done outside multiply state");

    // Divider finishes only while the sequencer waits for it
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_sts.done |-> state_reg == CS_DIV)
        else $error("divider done outside divide state");

    // Idle phase always has a cleared timer
    assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_IDLE |-> elapsed_reg == '0)
        else $error("timer not cleared in idle phase");

    // An accepted beat closes the input until its result is issued
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> !s_tready)
        else $error("input reopened before result issued");

endmodule : current_soft_start_ramp_top

`default_nettype wire

@@ dv/cssr_ramp_checker.sv @@
// Checker for the current soft-start ramp: tracks config writes, predicts the
// shaped current and phase per input beat, and compares them with result beats.
// Depends on cssr_pkg.
`timescale 1ns / 1ps

module cssr_ramp_checker import cssr_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_we,
    input  logic [CFG_ADDR_WIDTH-1:0] cfg_addr,
    input  logic [CFG_DATA_WIDTH-1:0] cfg_wdata,
    input  logic                      s_tvalid,
    input  logic                      s_tready,
    input  logic [S_DATA_WIDTH-1:0]   s_tdata,  // target_current, time_step
    input  logic                      m_tvalid,
    input  logic                      m_tready,
    input  logic [M_DATA_WIDTH-1:0]   m_tdata,  // shaped_current, phase, zero pad
    output int unsigned               fail_count,
    output int unsigned               outstanding,
    output int unsigned               results_seen
);

    typedef struct packed {
        phase_t                   phase;
        logic [CURRENT_WIDTH-1:0] shaped;
    } shaped_result_t;

    // Predicted results, oldest first
    shaped_result_t shaped_q[$];

    // Shadow registers and shaper state
    logic [TIME_WIDTH-1:0]   duration_r  = RAMP_DURATION_RST;
    logic [THRESH_WIDTH-1:0] start_thr_r = START_THRESHOLD_RST;
    logic [THRESH_WIDTH-1:0] stop_thr_r  = STOP_THRESHOLD_RST;
    phase_t                  phase_r     = PH_IDLE;
    logic [TIME_WIDTH-1:0]   elapsed_r   = '0;

    int unsigned errors    = 0;
    int unsigned results_n = 0;

    // Advance the shaper by one beat and return the result it produces
    function automatic shaped_result_t shape_target(logic [CURRENT_WIDTH-1:0] tgt,
                                                    logic [STEP_WIDTH-1:0] dt);
        shaped_result_t    res;
        logic              neg;
        longint unsigned   mag;
        longint unsigned   span;
        longint unsigned   quot;
        longint unsigned   quot_n;
        neg = tgt[CURRENT_WIDTH-1];
        mag = neg ? ((64'd1 << CURRENT_WIDTH) - 64'(tgt)) : 64'(tgt);
        res.shaped = '0;
        case (phase_r)
            PH_IDLE: begin
                if (mag > 64'(start_thr_r)) begin
                    phase_r   = PH_RAMP;
                    elapsed_r = '0;
                end
            end
            PH_RAMP: begin
                span = 64'(elapsed_r) + 64'(dt);
                if (span >= 64'(duration_r)) begin
                    // saturate the timer and hand over to pass-through
                    elapsed_r  = duration_r;
                    phase_r    = PH_NORMAL;
                    res.shaped = tgt;
                end else begin
                    elapsed_r  = span[TIME_WIDTH-1:0];
                    quot       = (mag * span) / 64'(duration_r);
                    quot_n     = 64'd0 - quot;
                    res.shaped = neg ? quot_n[CURRENT_WIDTH-1:0] : quot[CURRENT_WIDTH-1:0];
                end
            end
            PH_NORMAL: begin
                if (mag < 64'(stop_thr_r)) begin
                    phase_r   = PH_IDLE;
                    elapsed_r = '0;
                end
                res.shaped = tgt;
            end
            default: begin
                phase_r = PH_IDLE;
            end
        endcase
        res.phase = phase_r;
        return res;
    endfunction

    task automatic note_mismatch(string field, longint want_v, longint got_v);
        errors++;
        $error("%s mismatch: expected %0d, actual %0d", field, want_v, got_v);
    endtask

    always @(posedge aclk) begin
        shaped_result_t             want;
        logic [CURRENT_WIDTH-1:0]   got_shaped;
        logic [PHASE_WIDTH-1:0]     got_phase;
        if (!aresetn) begin
            duration_r  = RAMP_DURATION_RST;
            start_thr_r = START_THRESHOLD_RST;
            stop_thr_r  = STOP_THRESHOLD_RST;
            phase_r     = PH_IDLE;
            elapsed_r   = '0;
            shaped_q.delete();
        end else begin
            // Compare a result beat with the oldest prediction
            if (m_tvalid && m_tready) begin
                got_shaped = m_tdata[CURRENT_WIDTH-1:0];
                got_phase  = m_tdata[CURRENT_WIDTH +: PHASE_WIDTH];
                results_n++;
                if (shaped_q.size() == 0) begin
                    errors++;
                    $error("result beat with nothing predicted: shaped_current %0d, phase %0d",
                           $signed(got_shaped), got_phase);
                end else begin
                    want = shaped_q.pop_front();
                    if (got_shaped !== want.shaped)
                        note_mismatch("shaped_current", $signed(want.shaped),
                                      $signed(got_shaped));
                    if (got_phase !== want.phase)
                        note_mismatch("phase", want.phase, got_phase);
                end
            end

            // Track register writes, masked to register width
            if (cfg_we) begin
                case (cfg_addr)
                    CFG_RAMP_DURATION:   duration_r  = cfg_wdata[TIME_WIDTH-1:0];
                    CFG_START_THRESHOLD: start_thr_r = cfg_wdata[THRESH_WIDTH-1:0];
                    CFG_STOP_THRESHOLD:  stop_thr_r  = cfg_wdata[THRESH_WIDTH-1:0];
                    default: ;
                endcase
            end

            // Predict the result of each accepted input beat
            if (s_tvalid && s_tready)
                shaped_q.push_back(shape_target(s_tdata[CURRENT_WIDTH-1:0],
                                                s_tdata[CURRENT_WIDTH +: STEP_WIDTH]));
        end
        fail_count   <= errors;
        outstanding  <= shaped_q.size();
        results_seen <= results_n;
    end

endmodule : cssr_ramp_checker

@@ dv/tb_current_soft_start_ramp_top.sv @@
// Testbench top for current_soft_start_ramp_top: drives directed and random
// beats under several register settings and idle patterns, gives the verdict.
// Depends on cssr_pkg, the block and cssr_ramp_checker.
`timescale 1ns / 1ps

module tb_current_soft_start_ramp_top;
    import cssr_pkg::*;

    localparam int CYCLE_LIMIT    = 3_000_000;
    localparam int SETTING_COUNT  = 12;
    localparam int SETTING_BEATS  = 130;
    localparam int SETTLE_CYCLES  = 40;
    localparam int RAMP_BEAT_CAP  = 400;

    typedef enum int {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } idle_mode_t;

    logic                      aclk      = 1'b0;
    logic                      aresetn   = 1'b0;
    logic                      cfg_we    = 1'b0;
    logic [CFG_ADDR_WIDTH-1:0] cfg_addr  = '0;
    logic [CFG_DATA_WIDTH-1:0] cfg_wdata = '0;
    logic                      s_tvalid  = 1'b0;
    logic                      s_tready;
    logic [S_DATA_WIDTH-1:0]   s_tdata   = '0;  // target_current, time_step
    logic                      m_tvalid;
    logic                      m_tready  = 1'b0;
    logic [M_DATA_WIDTH-1:0]   m_tdata;         // shaped_current, phase, zero pad

    int unsigned fail_count;
    int unsigned outstanding;
    int unsigned results_seen;
    int unsigned beats_sent = 0;
    idle_mode_t  idle_mode  = IDLE_NONE;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    current_soft_start_ramp_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    cssr_ramp_checker u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .fail_count   (fail_count),
        .outstanding  (outstanding),
        .results_seen (results_seen)
    );

    // Stall the result side according to the current idle pattern
    always @(posedge aclk) begin
        case (idle_mode)
            IDLE_RECV: m_tready <= ($urandom_range(99, 0) >= 87);
            IDLE_BOTH: m_tready <= ($urandom_range(99, 0) >= 9);
            default:   m_tready <= 1'b1;
        endcase
    end

    // Give up on a hung block
    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("current_soft_start_ramp_top test failed");
        $finish;
    end

    // Send one beat, idling first when the current pattern asks for it
    task automatic send_beat(input logic [CURRENT_WIDTH-1:0] tgt,
                             input logic [STEP_WIDTH-1:0] dt);
        int unsigned pct;
        pct = (idle_mode == IDLE_SEND) ? 87 : (idle_mode == IDLE_BOTH) ? 9 : 0;
        if (pct != 0 && $urandom_range(99, 0) < pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99, 0) < pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_DATA_WIDTH'({dt, tgt});
        do @(posedge aclk); while (!s_tready);
        beats_sent++;
    endtask

    // Hold off the sender until every predicted result has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Write all three registers; junk in the unused upper bits of the thresholds
    task automatic program_regs(input logic [TIME_WIDTH-1:0] dur,
                                input logic [THRESH_WIDTH-1:0] start_thr,
                                input logic [THRESH_WIDTH-1:0] stop_thr);
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_RAMP_DURATION;
        cfg_wdata <= CFG_DATA_WIDTH'(dur);
        @(posedge aclk);
        cfg_addr  <= CFG_START_THRESHOLD;
        cfg_wdata <= {(CFG_DATA_WIDTH - THRESH_WIDTH)'($urandom), start_thr};
        @(posedge aclk);
        cfg_addr  <= CFG_STOP_THRESHOLD;
        cfg_wdata <= {(CFG_DATA_WIDTH - THRESH_WIDTH)'($urandom), stop_thr};
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // Target with a magnitude in [lo, hi] and a random sign; 32768 maps to the
    // most negative code
    function automatic logic [CURRENT_WIDTH-1:0] target_of_mag(int unsigned lo,
                                                               int unsigned hi);
        int unsigned mag;
        mag = $urandom_range(hi, lo);
        if ($urandom_range(1, 0) == 1)
            return CURRENT_WIDTH'(0 - mag);
        return CURRENT_WIDTH'(mag);
    endfunction

    // Mostly full start/ramp/normal/stop sequences, some pure noise
    task automatic run_setting(input int unsigned budget,
                               input logic [TIME_WIDTH-1:0] dur,
                               input logic [THRESH_WIDTH-1:0] start_thr,
                               input logic [THRESH_WIDTH-1:0] stop_thr);
        int unsigned       goal;
        int unsigned       n;
        int unsigned       k;
        longint unsigned   acc;
        longint unsigned   w;
        logic [STEP_WIDTH-1:0] dt;
        goal = beats_sent + budget;
        while (beats_sent < goal) begin
            if ($urandom_range(99, 0) < 80) begin
                // quiet beats at or below the start level
                repeat ($urandom_range(3, 0)) begin
                    if ($urandom_range(5, 0) == 0)
                        send_beat(target_of_mag(start_thr, start_thr), 16'($urandom));
                    else
                        send_beat(target_of_mag(0, start_thr), 16'($urandom));
                end
                send_beat(target_of_mag(start_thr + 1, 32768), 16'($urandom));

                // ramp: steps in [w/2, w] with w = 2*dur/n, so the ramp ends in at most about n beats
                n = $urandom_range(12, 1);
                w = (64'(dur) * 2) / n;
                if (w < 1)
                    w = 1;
                if (w > 65535)
                    w = 65535;
                acc = 0;
                k   = 0;
                while (acc < 64'(dur) && k < RAMP_BEAT_CAP) begin
                    dt = STEP_WIDTH'($urandom_range(w, w / 2));
                    send_beat(target_of_mag(0, 32768), dt);
                    acc += dt;
                    k++;
                end

                // pass-through beats, then a drop below the stop level
                repeat ($urandom_range(6, 1)) begin
                    if ($urandom_range(5, 0) == 0)
                        send_beat(target_of_mag(stop_thr, stop_thr), 16'($urandom));
                    else
                        send_beat(target_of_mag(stop_thr, 32768), 16'($urandom));
                end
                if (stop_thr != 0)
                    send_beat(target_of_mag(0, stop_thr - 1), 16'($urandom));
                else
                    send_beat(16'($urandom), 16'($urandom));
            end else begin
                repeat ($urandom_range(6, 1))
                    send_beat(16'($urandom), 16'($urandom));
            end
        end
    endtask

    initial begin
        logic [TIME_WIDTH-1:0]   dur;
        logic [THRESH_WIDTH-1:0] start_thr;
        logic [THRESH_WIDTH-1:0] stop_thr;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: reset register values, equal thresholds, full ramp with
        // timer saturation, stop, restart on the most negative target
        send_beat(16'd0, 16'd0);
        send_beat(16'd100, 16'hFFFF);
        send_beat(16'(-100), 16'd1);
        send_beat(16'h7FFF, 16'hFFFF);
        send_beat(16'h8000, 16'hFFFF);
        send_beat(16'h7FFF, 16'd0);
        for (int i = 0; i < 7; i++)
            send_beat(i[0] ? 16'h8000 : 16'h7FFF, 16'hFFFF);
        send_beat(16'h8000, 16'd12345);
        send_beat(16'd50, 16'd0);
        send_beat(16'(-50), 16'd0);
        send_beat(16'(-49), 16'd0);
        send_beat(16'h8000, 16'd0);
        send_beat(16'd0, 16'hFFFF);

        // Directed: zero duration ends the ramp at once; extreme thresholds
        drain_results();
        program_regs('0, '0, 15'h7FFF);
        send_beat(16'd1234, 16'd0);
        send_beat(16'd32766, 16'd7);
        send_beat(16'd1, 16'd0);
        send_beat(16'hFFFF, 16'd0);
        send_beat(16'h8000, 16'd0);
        send_beat(16'd0, 16'd0);

        // Random: a register setting per pass, idle pattern rotating
        for (int idx = 0; idx < SETTING_COUNT; idx++) begin
            case (idx)
                0: begin dur = 24'd1000;     start_thr = 15'd100;    stop_thr = 15'd50;    end
                1: begin dur = 24'd1;        start_thr = '0;         stop_thr = '0;        end
                2: begin dur = 24'hFFFFFF;   start_thr = 15'h7FFF;   stop_thr = 15'h7FFF;  end
                3: begin
                    dur       = '0;
                    start_thr = 15'($urandom);
                    stop_thr  = 15'($urandom);
                end
                4: begin
                    dur       = 24'($urandom_range(5000, 1));
                    start_thr = 15'($urandom_range(2000, 0));
                    stop_thr  = 15'($urandom_range(2000, 0));
                end
                5: begin dur = 24'd65536;    start_thr = '0;         stop_thr = 15'h7FFF;  end
                default: begin
                    dur       = 24'($urandom_range(300000, 1));
                    start_thr = 15'($urandom);
                    stop_thr  = 15'($urandom);
                end
            endcase
            drain_results();
            program_regs(dur, start_thr, stop_thr);
            idle_mode = idle_mode_t'(idx % 4);
            run_setting(SETTING_BEATS, dur, start_thr, stop_thr);
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("Ran %0d beats (directed, then %0d register settings under four idle patterns)",
                 beats_sent, SETTING_COUNT);
        $display("and compared %0d result beats.", results_seen);
        if (fail_count == 0) begin
            $display("current_soft_start_ramp_top test passed");
        end else begin
            $display("current_soft_start_ramp_top test failed");
        end
        $finish;
    end

endmodule : tb_current_soft_start_ramp_top
